[src/wsd_pkg.sv]
package wsd_pkg;

   // width in bits of the largest frame length accepted
   localparam int LENGTH_BITS = 64;
   // the length accumulator always holds a full 64-bit extended length
   localparam int LEN_W = 64;
   localparam logic [LEN_W-1:0] LEN_OVER_MASK = (LENGTH_BITS >= LEN_W) ? '0 :
      ~((LEN_W'(1) << LENGTH_BITS) - LEN_W'(1));

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   typedef enum logic [1:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_CLOSED  = 3'd1,
      ST_MASKED  = 3'd2,
      ST_BINARY  = 3'd3,
      ST_STRAY   = 3'd4,
      ST_BADOP   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CL_TEXT,
      CL_PING,
      CL_PONG,
      CL_STOP
   } class_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       data_valid;
      logic       stream_kind;
      logic       frame_end;
      logic       message_end;
      status_type status;
   } result_type;

endpackage

[src/wsd_req_if.sv]
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

[src/wsd_rsp_if.sv]
interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       data_valid;
   logic       stream_kind;
   logic       frame_end;
   logic       message_end;
   logic [2:0] status;

   modport source (output valid, output data_byte, output data_valid, output stream_kind,
                   output frame_end, output message_end, output status, input ready);
   modport sink (input valid, input data_byte, input data_valid, input stream_kind,
                 input frame_end, input message_end, input status, output ready);
endinterface

[src/wsd_parser.sv]
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       ext_left_ff, ext_left_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             fin_ff, fin_in;
   logic             frag_ff, frag_in;
   logic             halted_ff, halted_in;

   class_type        cls;
   status_type       cls_st;

   logic             do_len, do_end, end_emitted;
   logic [LEN_W-1:0] len_val, rem_shift, rem_dec;
   logic [3:0]       ext_dec;
   logic             last;

   always_comb begin
      cls    = CL_STOP;
      cls_st = ST_OK;
      case (opcode_ff)
         OP_TEXT: cls = CL_TEXT;
         OP_CONT: begin
            if (frag_ff) begin
               cls = CL_TEXT;
            end else begin
               cls_st = ST_STRAY;
            end
         end
         OP_PING:  cls = CL_PING;
         OP_PONG:  cls = CL_PONG;
         OP_CLOSE: cls_st = ST_CLOSED;
         OP_BIN:   cls_st = ST_BINARY;
         default:  cls_st = ST_BADOP;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      ext_left_in = ext_left_ff;
      remain_in   = remain_ff;
      opcode_in   = opcode_ff;
      fin_in      = fin_ff;
      frag_in     = frag_ff;
      halted_in   = halted_ff;
      res_valid   = 1'b0;
      res         = '0;
      do_len      = 1'b0;
      do_end      = 1'b0;
      end_emitted = 1'b0;
      len_val     = '0;
      rem_shift   = {remain_ff[LEN_W-9:0], rx_byte};
      rem_dec     = remain_ff - LEN_W'(remain_ff != '0);
      ext_dec     = ext_left_ff - 4'(ext_left_ff != 4'd0);
      last        = (rem_dec == '0);

      if (step_en && !halted_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               if (rx_byte[7]) begin
                  halted_in  = 1'b1;
                  res_valid  = 1'b1;
                  res.frame_end = 1'b1;
                  res.status = ST_MASKED;
               end else if (rx_byte[6:0] == LEN7_EXT16) begin
                  remain_in   = '0;
                  ext_left_in = EXT16_BYTES;
                  phase_in    = PH_EXT;
               end else if (rx_byte[6:0] == LEN7_EXT64) begin
                  remain_in   = '0;
                  ext_left_in = EXT64_BYTES;
                  phase_in    = PH_EXT;
               end else begin
                  do_len  = 1'b1;
                  len_val = LEN_W'(rx_byte[6:0]);
               end
            end
            PH_EXT: begin
               remain_in   = rem_shift;
               ext_left_in = ext_dec;
               if (ext_dec == 4'd0) begin
                  do_len  = 1'b1;
                  len_val = rem_shift;
               end
            end
            PH_PAYLOAD: begin
               remain_in = rem_dec;
               if (cls == CL_TEXT || cls == CL_PING) begin
                  res_valid       = 1'b1;
                  res.data_byte   = rx_byte;
                  res.data_valid  = 1'b1;
                  res.stream_kind = (cls == CL_PING);
                  res.frame_end   = last;
                  res.message_end = (cls == CL_TEXT) && last && fin_ff;
                  end_emitted     = 1'b1;
               end
               do_end = last;
            end
            default: ;
         endcase

         // length complete: oversize check, then empty frame or payload
         if (do_len) begin
            remain_in = len_val;
            if ((len_val & LEN_OVER_MASK) != '0) begin
               halted_in     = 1'b1;
               res_valid     = 1'b1;
               res.frame_end = 1'b1;
               res.status    = ST_BADOP;
            end else if (len_val == '0) begin
               do_end = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         if (do_end) begin
            phase_in  = PH_HDR0;
            remain_in = '0;
            case (cls)
               CL_TEXT: begin
                  frag_in = !fin_ff;
                  if (!end_emitted && fin_ff) begin
                     res_valid       = 1'b1;
                     res.frame_end   = 1'b1;
                     res.message_end = 1'b1;
                  end
               end
               CL_PING: begin
                  if (!end_emitted) begin
                     res_valid       = 1'b1;
                     res.stream_kind = 1'b1;
                     res.frame_end   = 1'b1;
                  end
               end
               CL_PONG: ;
               default: begin
                  halted_in     = 1'b1;
                  res_valid     = 1'b1;
                  res.frame_end = 1'b1;
                  res.status    = cls_st;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         ext_left_ff <= '0;
         remain_ff   <= '0;
         opcode_ff   <= '0;
         fin_ff      <= 1'b0;
         frag_ff     <= 1'b0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         remain_ff   <= remain_in;
         opcode_ff   <= opcode_in;
         fin_ff      <= fin_in;
         frag_ff     <= frag_in;
         halted_ff   <= halted_in;
      end
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("parser left the halted state");

   a_bad_status_halts: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_OK |=> halted_ff)
      else $error("error status given without halting");

   a_data_is_ok: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.data_valid |-> res.status == ST_OK)
      else $error("payload byte carries an error status");

   a_msg_end_text: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.message_end |-> res.frame_end && !res.stream_kind)
      else $error("message end outside the last text result of a frame");

   a_no_result_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced while halted");

endmodule

[src/websocket_frame_deframer.sv]
// channel   dir  handshake            payload
// req_chan  in   valid/ready          rx_byte[7:0]
// rsp_chan  out  valid/ready          data_byte, data_valid, stream_kind,
//                                     frame_end, message_end, status[2:0]
//
// one byte accepted per clock unless req_chan.ready is low; an accepted byte waits
// in the input register, then the parser writes its result into the output register
// synchronous reset returns the parser to the first header byte and empties
// both registers
// a stalled rsp_chan holds the output register; req_chan.ready drops only
// when the input and output registers are both full and the output is not taken
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   wsd_req_if.sink    req_chan,
   wsd_rsp_if.source  rsp_chan
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;

   logic       advance;
   logic       step_en;
   logic       res_valid;
   result_type res;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= step_en && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.data_byte   = out_ff.data_byte;
   assign rsp_chan.data_valid  = out_ff.data_valid;
   assign rsp_chan.stream_kind = out_ff.stream_kind;
   assign rsp_chan.frame_end   = out_ff.frame_end;
   assign rsp_chan.message_end = out_ff.message_end;
   assign rsp_chan.status      = out_ff.status;

   a_in_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("waiting item in the input register was lost");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result changed");

   a_step_only_when_free: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid |=> out_valid_ff)
      else $error("parser result dropped");

endmodule
